@@ src/cbra_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cbra_pkg;

	// Map word read or written per memory access, and the scan slice per cycle.
	localparam int WORD_W      = 32;
	localparam int WORD_SHIFT  = 5;
	localparam int CHUNK_W     = 8;
	localparam int CHUNK_SHIFT = 3;
	localparam int SUB_W       = WORD_SHIFT - CHUNK_SHIFT;

	// Block positions reach a free's first block plus its count, so they need one bit more
	// than a count.
	localparam int BLK_W   = 14;
	localparam int CNT_W   = 13;
	localparam int START_W = 12;

	// Only blocks below the largest programmable total are ever touched.
	localparam int POS_LIMIT = 8192;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic REG_TOTAL = 1'b0;
	localparam logic REG_FIRST = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_SCAN_RD,
		ST_SCAN_PROC,
		ST_SCAN_END,
		ST_RMW_RD,
		ST_RMW_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic rd;
		logic proc;
		logic mark_init;
		logic wr;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic range_empty;
		logic op_free;
		logic word_done;
		logic scan_stop;
		logic best_zero;
		logic at_last;
	} status_t;

endpackage

`default_nettype wire

@@ src/contiguous_block_run_allocator.sv @@
// An allocate checks its range, scans map words for a run, then reads and writes each
// granted word before the done strobe; a free checks, then reads and writes each word.
// It takes one item at a time; the scan reads one 32-block map word per access
// and checks 8 blocks a cycle between reads; all-free and all-used words take one step.
// After reset a clearing pass zeroes the ceil(min(MAP_BLOCKS, 8192) / 32) map words
// (128 by default) while busy is high; results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_block_run_allocator #(
	parameter int MAP_BLOCKS = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [11:0] free_base,
	input  wire logic [12:0] run_count,
	output logic             done,
	output logic      [11:0] granted_start,
	output logic      [12:0] granted_count,
	output logic             no_space,
	output logic      [12:0] used_blocks,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	cbra_pkg::cmd_t    cmd;
	cbra_pkg::status_t status;
	logic [12:0]       volume_blocks;
	logic [11:0]       first_data_block;

	cbra_regs u_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.volume_blocks    (volume_blocks),
		.first_data_block (first_data_block)
	);

	cbra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.status (status)
	);

	cbra_dp #(
		.MAP_BLOCKS (MAP_BLOCKS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.volume_blocks    (volume_blocks),
		.first_data_block (first_data_block),
		.op               (op),
		.free_base        (free_base),
		.run_count        (run_count),
		.granted_start    (granted_start),
		.granted_count    (granted_count),
		.no_space         (no_space),
		.used_blocks      (used_blocks)
	);

endmodule

`default_nettype wire

@@ src/cbra_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cbra_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [12:0] volume_blocks,
	output logic      [11:0] first_data_block
);

	logic [12:0] total_q;
	logic [11:0] first_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= 13'd4096;
			first_q <= 12'd1;
		end else if (wr_en) begin
			case (paddr[2])
				cbra_pkg::REG_TOTAL: total_q <= pwdata[12:0];
				cbra_pkg::REG_FIRST: first_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			cbra_pkg::REG_TOTAL: prdata = {19'd0, total_q};
			cbra_pkg::REG_FIRST: prdata = {20'd0, first_q};
			default:             prdata = '0;
		endcase
	end

	assign volume_blocks    = total_q;
	assign first_data_block = first_q;

endmodule

`default_nettype wire

@@ src/cbra_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cbra_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   done,
	output cbra_pkg::cmd_t         cmd,
	input  wire cbra_pkg::status_t status
);

	cbra_pkg::state_t state_q, state_nxt;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbra_pkg::ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == cbra_pkg::ST_FINISH);
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			cbra_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.clr_last) state_nxt = cbra_pkg::ST_IDLE;
			end
			cbra_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = cbra_pkg::ST_CHECK;
				end
			end
			cbra_pkg::ST_CHECK: begin
				if (status.range_empty) state_nxt = cbra_pkg::ST_FINISH;
				else if (status.op_free) state_nxt = cbra_pkg::ST_RMW_RD;
				else state_nxt = cbra_pkg::ST_SCAN_RD;
			end
			cbra_pkg::ST_SCAN_RD: begin
				cmd.rd    = 1'b1;
				state_nxt = cbra_pkg::ST_SCAN_PROC;
			end
			cbra_pkg::ST_SCAN_PROC: begin
				cmd.proc = 1'b1;
				if (status.scan_stop) state_nxt = cbra_pkg::ST_SCAN_END;
				else if (status.word_done) state_nxt = cbra_pkg::ST_SCAN_RD;
			end
			cbra_pkg::ST_SCAN_END: begin
				if (status.best_zero) begin
					state_nxt = cbra_pkg::ST_FINISH;
				end else begin
					cmd.mark_init = 1'b1;
					state_nxt     = cbra_pkg::ST_RMW_RD;
				end
			end
			cbra_pkg::ST_RMW_RD: begin
				cmd.rd    = 1'b1;
				state_nxt = cbra_pkg::ST_RMW_WR;
			end
			cbra_pkg::ST_RMW_WR: begin
				cmd.wr = 1'b1;
				if (status.at_last) state_nxt = cbra_pkg::ST_FINISH;
				else state_nxt = cbra_pkg::ST_RMW_RD;
			end
			cbra_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				state_nxt  = cbra_pkg::ST_IDLE;
			end
			default: state_nxt = cbra_pkg::ST_IDLE;
		endcase
	end

	assign busy = (state_q != cbra_pkg::ST_IDLE);
	assign done = done_q;

`ifndef ASSERT_OFF
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe lasted more than one cycle");
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cbra_pkg::ST_IDLE && start) |=> (state_q == cbra_pkg::ST_CHECK))
		else $error("accepted item did not start processing");
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == cbra_pkg::ST_FINISH))
		else $error("result strobe without a finished item");
`endif

endmodule

`default_nettype wire

@@ src/cbra_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cbra_dp #(
	parameter int MAP_BLOCKS = 4096
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cbra_pkg::cmd_t cmd,
	output cbra_pkg::status_t   status,
	input  wire logic [12:0]    volume_blocks,
	input  wire logic [11:0]    first_data_block,
	input  wire logic           op,
	input  wire logic [11:0]    free_base,
	input  wire logic [12:0]    run_count,
	output logic      [11:0]    granted_start,
	output logic      [12:0]    granted_count,
	output logic                no_space,
	output logic      [12:0]    used_blocks
);

	localparam int WW  = cbra_pkg::WORD_W;
	localparam int WS  = cbra_pkg::WORD_SHIFT;
	localparam int CW  = cbra_pkg::CHUNK_W;
	localparam int CS  = cbra_pkg::CHUNK_SHIFT;
	localparam int SW  = cbra_pkg::SUB_W;
	localparam int BW  = cbra_pkg::BLK_W;
	localparam int NW  = cbra_pkg::CNT_W;
	localparam int STW = cbra_pkg::START_W;

	localparam int EFF_BLOCKS = (MAP_BLOCKS < cbra_pkg::POS_LIMIT) ?
		MAP_BLOCKS : cbra_pkg::POS_LIMIT;
	localparam int NWORDS = (EFF_BLOCKS + WW - 1) / WW;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

	localparam logic [BW-1:0] EFF_LIM   = BW'(EFF_BLOCKS);
	localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);
	localparam logic [SW-1:0] SUB_LAST  = SW'((WW / CW) - 1);

	logic [WW-1:0] map_mem [NWORDS];
	logic [WW-1:0] rdata_q;

	logic [AW-1:0]  clr_addr_q;
	logic [AW-1:0]  waddr_q;
	logic [SW-1:0]  sub_q;
	logic           op_q;
	logic [NW-1:0]  count_q;
	logic [BW-1:0]  lo_q, hi_q;
	logic [NW-1:0]  cur_len_q, long_len_q, used_q;
	logic [BW-1:0]  cur_start_q, long_start_q;
	logic [STW-1:0] granted_start_q;
	logic [NW-1:0]  granted_count_q, used_blocks_q;
	logic           no_space_q;

	logic [BW-1:0] lim, lo_new, hi_new, free_end, hi_m1, wordpos;
	logic [AW-1:0] last_w;
	logic          at_last;
	logic [WW-1:0] mask, eff, wdata;
	logic [WS:0]   pop;

	logic [NW-1:0] nxt_cur_len, nxt_long_len;
	logic [BW-1:0] nxt_cur_start, nxt_long_start;
	logic          nxt_found, scan_done;

	// Effective block limit and the block range of a new request.
	assign lim      = ({1'b0, volume_blocks} < EFF_LIM) ? BW'(volume_blocks) : EFF_LIM;
	assign free_end = BW'(free_base) + BW'(run_count);
	assign lo_new   = (op == cbra_pkg::OP_FREE) ? BW'(free_base) : BW'(first_data_block);
	assign hi_new   = (op == cbra_pkg::OP_FREE && free_end < lim) ? free_end : lim;

	assign hi_m1   = hi_q - 1'b1;
	assign last_w  = AW'(hi_m1 >> WS);
	assign at_last = (waddr_q == last_w);
	assign wordpos = BW'(waddr_q) << WS;

	always_comb begin : range_mask
		logic [BW-1:0] p;
		p = '0;
		for (int i = 0; i < WW; i++) begin
			p       = wordpos + BW'(i);
			mask[i] = (p >= lo_q) && (p < hi_q);
		end
	end

	// Blocks outside the scan range look used, so they only break the current run.
	assign eff = rdata_q | ~mask;

	always_comb begin : scan_step
		logic [NW-1:0] c_len, b_len;
		logic [BW-1:0] c_start, b_start, p;
		logic          f;
		logic [NW:0]   sum32;
		c_len     = cur_len_q;
		b_len     = long_len_q;
		c_start   = cur_start_q;
		b_start   = long_start_q;
		f         = 1'b0;
		p         = '0;
		sum32     = {1'b0, cur_len_q} + (NW + 1)'(WW);
		scan_done = 1'b0;
		if (sub_q == '0 && &eff) begin
			c_len     = '0;
			scan_done = 1'b1;
		end else if (sub_q == '0 && ~|eff) begin
			// A whole free word extends the current run in one step.
			if (cur_len_q == '0) c_start = wordpos;
			if (sum32 >= {1'b0, count_q}) begin
				f       = 1'b1;
				b_len   = count_q;
				b_start = c_start;
			end else begin
				c_len = sum32[NW-1:0];
				if (c_len > b_len) begin
					b_len   = c_len;
					b_start = c_start;
				end
			end
			scan_done = 1'b1;
		end else begin
			for (int j = 0; j < CW; j++) begin
				p = wordpos + BW'({sub_q, CS'(j)});
				if (!f) begin
					if (!eff[{sub_q, CS'(j)}]) begin
						if (c_len == '0) c_start = p;
						c_len = c_len + 1'b1;
						if (c_len > b_len) begin
							b_len   = c_len;
							b_start = c_start;
						end
						if (c_len >= count_q) f = 1'b1;
					end else begin
						c_len = '0;
					end
				end
			end
			scan_done = f || (sub_q == SUB_LAST);
		end
		nxt_cur_len    = c_len;
		nxt_cur_start  = c_start;
		nxt_long_len   = b_len;
		nxt_long_start = b_start;
		nxt_found      = f;
	end

	assign pop   = (WS + 1)'($countones(rdata_q & mask));
	assign wdata = (op_q == cbra_pkg::OP_FREE) ? (rdata_q & ~mask) : (rdata_q | mask);

	always_ff @(posedge clk) begin
		if (cmd.clr) map_mem[clr_addr_q] <= '0;
		else if (cmd.wr) map_mem[waddr_q] <= wdata;
		if (cmd.rd) rdata_q <= map_mem[waddr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q      <= '0;
			waddr_q         <= '0;
			sub_q           <= '0;
			op_q            <= cbra_pkg::OP_ALLOC;
			count_q         <= '0;
			lo_q            <= '0;
			hi_q            <= '0;
			cur_len_q       <= '0;
			cur_start_q     <= '0;
			long_len_q      <= '0;
			long_start_q    <= '0;
			used_q          <= '0;
			granted_start_q <= '0;
			granted_count_q <= '0;
			no_space_q      <= 1'b0;
			used_blocks_q   <= '0;
		end else begin
			if (cmd.clr) clr_addr_q <= clr_addr_q + 1'b1;
			if (cmd.load) begin
				op_q         <= op;
				count_q      <= run_count;
				lo_q         <= lo_new;
				hi_q         <= hi_new;
				waddr_q      <= AW'(lo_new >> WS);
				sub_q        <= '0;
				cur_len_q    <= '0;
				cur_start_q  <= '0;
				long_len_q   <= '0;
				long_start_q <= '0;
			end
			if (cmd.proc) begin
				cur_len_q    <= nxt_cur_len;
				cur_start_q  <= nxt_cur_start;
				long_len_q   <= nxt_long_len;
				long_start_q <= nxt_long_start;
				if (scan_done) begin
					sub_q   <= '0;
					waddr_q <= waddr_q + 1'b1;
				end else begin
					sub_q <= sub_q + 1'b1;
				end
			end
			if (cmd.mark_init) begin
				// The best run never exceeds the want, so it is the grant.
				lo_q    <= long_start_q;
				hi_q    <= long_start_q + BW'(long_len_q);
				waddr_q <= AW'(long_start_q >> WS);
				used_q  <= used_q + long_len_q;
			end
			if (cmd.wr) begin
				waddr_q <= waddr_q + 1'b1;
				if (op_q == cbra_pkg::OP_FREE) used_q <= used_q - NW'(pop);
			end
			if (cmd.finish) begin
				granted_start_q <= (long_len_q != '0) ? long_start_q[STW-1:0] : '0;
				granted_count_q <= long_len_q;
				no_space_q      <= (op_q == cbra_pkg::OP_ALLOC) && (count_q != '0) &&
					(long_len_q == '0);
				used_blocks_q   <= used_q;
			end
		end
	end

	always_comb begin
		status             = '0;
		status.clr_last    = (clr_addr_q == LAST_WORD);
		status.range_empty = (lo_q >= hi_q) ||
			((op_q == cbra_pkg::OP_ALLOC) && (count_q == '0));
		status.op_free     = (op_q == cbra_pkg::OP_FREE);
		status.word_done   = scan_done;
		status.scan_stop   = scan_done && (nxt_found || at_last);
		status.best_zero   = (long_len_q == '0);
		status.at_last     = at_last;
	end

	assign granted_start = granted_start_q;
	assign granted_count = granted_count_q;
	assign no_space      = no_space_q;
	assign used_blocks   = used_blocks_q;

`ifndef ASSERT_OFF
	a_best_within_want: assert property (@(posedge clk) disable iff (!arst_n)
		long_len_q <= count_q)
		else $error("longest run grew past the requested count");
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> (waddr_q <= last_w))
		else $error("map write beyond the last word of the range");
	a_free_no_growth: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr && op_q == cbra_pkg::OP_FREE) |=> (used_q <= $past(used_q)))
		else $error("used counter grew during a free");
`endif

endmodule

`default_nettype wire
